FILE: design/ert_pkg.sv
// ----------------------------------------------------------------------------
// ert_pkg: shared types and constants of the exit record table
// Item formats for the request and response channels and the default depth.
// ----------------------------------------------------------------------------
package ert_pkg;

	localparam int ERT_DEPTH = 64;
	localparam int SLOT_W    = 6;
	localparam int ID_W      = 32;
	localparam int CODE_W    = 64;
	localparam int CNT_W     = 32;

	// Request kinds
	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [ID_W-1:0]   proc_id;
		logic [CODE_W-1:0] code_in;
		logic [CNT_W-1:0]  preempts_in;
		logic [CNT_W-1:0]  ticks_in;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot_used;
		logic [CODE_W-1:0] code_out;
		logic [CNT_W-1:0]  preempts_out;
		logic [CNT_W-1:0]  ticks_out;
	} rsp_t;

endpackage

FILE: design/ert_stream_if.sv
// ----------------------------------------------------------------------------
// ert_stream_if: valid/ready channel
// Carries one item of type T per handshake.
// ----------------------------------------------------------------------------
interface ert_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: design/ert_ram.sv
// ----------------------------------------------------------------------------
// ert_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ert_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: design/exit_record_table.sv
// ----------------------------------------------------------------------------
// exit_record_table: table of process exit records
// Stores exit records and hands them back, consuming them, on lookup by id.
// ----------------------------------------------------------------------------
// One item is worked at a time and every item gives exactly one response
// item. A record item scans the valid marks from slot 0, one slot a cycle,
// for the lowest free slot; with the table full it overwrites the slot under
// the replacement pointer and advances that pointer. A lookup item reads the
// id memory one slot a cycle from slot 0 and stops at the first valid match;
// the record's payload is then fetched from the data memory and the slot is
// freed. The length of both scans is set by the single read port of the id
// memory and the one-slot-a-cycle scan. The valid marks live in flip-flops
// and clear at reset, so no clearing pass is needed. The response sits in
// an output register, so a stalled sink holds only the final step of the
// next item.
// ----------------------------------------------------------------------------
module exit_record_table
	import ert_pkg::*;
#(
	parameter int TABLE_DEPTH = ERT_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	ert_stream_if.sink   req,
	ert_stream_if.source rsp
);
	localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int DATA_W = CODE_W + 2 * CNT_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FREE,
		ST_WRITE,
		ST_SCAN,
		ST_FETCH,
		ST_FILL,
		ST_DONE
	} state_t;

	state_t state_q;

	// latched request
	logic [ID_W-1:0]   pid_q;
	logic [DATA_W-1:0] payload_q;

	// scan control
	logic [IDX_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  addr_s1;
	logic              vld_s1;
	logic [IDX_W-1:0]  slot_q;
	logic [IDX_W-1:0]  repl_ptr_q;
	logic [TABLE_DEPTH-1:0] valid_q;

	// pending result and output register
	rsp_t res_q;
	rsp_t out_q;
	logic out_vld_q;

	// memories
	logic              mem_we;
	logic [ID_W-1:0]   id_rdata;
	logic [DATA_W-1:0] data_rdata;
	logic              hit;
	logic              out_free;
	logic              out_load;

	assign mem_we   = (state_q == ST_WRITE);
	assign hit      = vld_s1 && valid_q[addr_s1] && (id_rdata == pid_q);
	assign out_free = !out_vld_q || rsp.ready;
	assign out_load = (state_q == ST_DONE) && out_free;

	ert_ram #(
		.WIDTH (ID_W),
		.DEPTH (TABLE_DEPTH)
	) u_id_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot_q),
		.wdata (pid_q),
		.raddr (cnt_q),
		.rdata (id_rdata)
	);

	ert_ram #(
		.WIDTH (DATA_W),
		.DEPTH (TABLE_DEPTH)
	) u_data_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot_q),
		.wdata (payload_q),
		.raddr (slot_q),
		.rdata (data_rdata)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	// payload registers: no reset needed
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			pid_q     <= req.data.proc_id;
			payload_q <= {req.data.code_in, req.data.preempts_in, req.data.ticks_in};
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			addr_s1    <= '0;
			vld_s1     <= 1'b0;
			slot_q     <= '0;
			repl_ptr_q <= '0;
			valid_q    <= '0;
			res_q      <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			// load the output item, or drop it once taken
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						cnt_q  <= '0;
						vld_s1 <= 1'b0;
						state_q <= (req.data.kind == KIND_LOOKUP) ? ST_SCAN : ST_FREE;
					end
				end

				// hunt for the lowest free slot, fall back on the pointer
				ST_FREE: begin
					if (!valid_q[cnt_q]) begin
						slot_q  <= cnt_q;
						state_q <= ST_WRITE;
					end else if (cnt_q == LAST_IDX) begin
						slot_q     <= repl_ptr_q;
						repl_ptr_q <= (repl_ptr_q == LAST_IDX) ? '0 : repl_ptr_q + 1'b1;
						state_q    <= ST_WRITE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end

				ST_WRITE: begin
					valid_q[slot_q] <= 1'b1;
					res_q           <= {1'b0, SLOT_W'(slot_q), {DATA_W{1'b0}}};
					state_q         <= ST_DONE;
				end

				// issue one id read a cycle, compare the previous one
				ST_SCAN: begin
					if (hit) begin
						slot_q           <= addr_s1;
						valid_q[addr_s1] <= 1'b0;
						state_q          <= ST_FETCH;
					end else if (vld_s1 && addr_s1 == LAST_IDX) begin
						res_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						addr_s1 <= cnt_q;
						vld_s1  <= 1'b1;
						cnt_q   <= cnt_q + 1'b1;
					end
				end

				// data memory read of the matched slot is in flight
				ST_FETCH: begin
					state_q <= ST_FILL;
				end

				ST_FILL: begin
					res_q.found        <= 1'b1;
					res_q.slot_used    <= SLOT_W'(slot_q);
					res_q.code_out     <= data_rdata[DATA_W-1 -: CODE_W];
					res_q.preempts_out <= data_rdata[2*CNT_W-1 -: CNT_W];
					res_q.ticks_out    <= data_rdata[CNT_W-1:0];
					state_q            <= ST_DONE;
				end

				// hold until the output register is free
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
